/* hdl/zone_status_link_endpoint_unit_defines.svh */
// assertion macros for the zone status link endpoint checker
// expects clk and rst_n in the scope of each use
`ifndef ZONE_STATUS_LINK_ENDPOINT_UNIT_DEFINES_SVH
`define ZONE_STATUS_LINK_ENDPOINT_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define ZSL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zsl port check failed");

// next-cycle implication, off during reset
`define ZSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zsl port check failed");

// next-cycle implication that also holds through reset
`define ZSL_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("zsl port check failed");

`endif

/* hdl/zsl_pkg.sv */
// shared types, constants and crc helper for the zone status link endpoint
// no dependencies
package zsl_pkg;

  localparam logic [7:0] FRAME_SOF      = 8'hAA;
  localparam logic [7:0] FRAME_EOF      = 8'h55;
  localparam logic [7:0] CRC_POLY       = 8'h8C;
  localparam logic [7:0] CMD_STATUS     = 8'h81;
  localparam logic [7:0] CMD_REQUEST    = 8'h01;
  localparam logic [7:0] SRC_STATUS     = 8'h00;
  localparam logic [7:0] ZONE_RSVD_MASK = 8'hC0;

  localparam int unsigned BODY_LEN   = 6;
  localparam int unsigned CRC_STAGES = BODY_LEN;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FALLBACK   = 2'd0;
  localparam cfg_idx_t REG_CONFIRM    = 2'd1;
  localparam cfg_idx_t REG_MISS_LIMIT = 2'd2;

  localparam logic MODE_RECEIVE = 1'b0;
  localparam logic MODE_SEND    = 1'b1;

  typedef logic [3:0] byte_idx_t;
  localparam byte_idx_t IDX_SOF  = 4'd0;
  localparam byte_idx_t IDX_SRC  = 4'd1;
  localparam byte_idx_t IDX_NODE = 4'd2;
  localparam byte_idx_t IDX_SEQ  = 4'd3;
  localparam byte_idx_t IDX_CMD  = 4'd4;
  localparam byte_idx_t IDX_VAR  = 4'd5;
  localparam byte_idx_t IDX_ARG  = 4'd6;
  localparam byte_idx_t IDX_CRC  = 4'd7;
  localparam byte_idx_t IDX_EOF  = 4'd8;

  typedef enum logic [3:0] {
    ST_TX       = 4'd0,
    ST_SKIP     = 4'd1,
    ST_FRAMING  = 4'd2,
    ST_CHECK    = 4'd3,
    ST_OTHER    = 4'd4,
    ST_MASK     = 4'd5,
    ST_PENDING  = 4'd6,
    ST_MISMATCH = 4'd7,
    ST_UNLOCK   = 4'd8,
    ST_ACCEPT   = 4'd9
  } status_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] frame_start;
    logic [7:0] frame_node;
    logic [7:0] frame_source;
    logic [7:0] frame_sequence;
    logic [7:0] frame_command;
    logic [7:0] frame_variant;
    logic [7:0] frame_zones;
    logic [7:0] frame_check;
    logic [7:0] frame_stop;
    logic [7:0] request_arg;
    logic       bus_blocked;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] tx_byte;
    logic       last;
    logic [5:0] zone_mask;
    logic       mask_changed;
    logic       link_came_up;
    logic       node_locked;
    logic [7:0] node_address;
    logic       awaiting_reply;
  } out_item_t;

  // one classified item between the front and the back
  typedef struct packed {
    logic       is_tx;
    status_t    status;
    logic [7:0] node;
    logic [7:0] seq;
    logic [7:0] arg;
    logic [5:0] zone_mask;
    logic       mask_changed;
    logic       link_came_up;
    logic       node_locked;
    logic [7:0] node_address;
    logic       awaiting_reply;
  } job_t;

  // one body byte into a crc-8 reflected register
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hdl/zone_status_link_endpoint_unit.sv */
// Zone status link endpoint: checks received 9-byte frames (AA, six body
// bytes, crc-8 reflected 0x8C, 55), learns and locks the node address, tracks
// zone mask and online state, and builds numbered request frames. Both sides
// behave as queues. An item is taken every cycle while the front pipeline
// moves; a received frame passes six crc stages, one queue slot and the
// output register before its one result appears. A request gives nine result
// beats, one per cycle while the result side takes them, so the back end sets
// the sustained rate: one beat per received frame or skipped request, nine
// per sent request. A four-entry queue between the classifier and the byte
// builder lets input keep flowing while a request frame goes out. Depends on
// zsl_pkg, zsl_front, zsl_job_fifo, zsl_back.
module zone_status_link_endpoint_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  zsl_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output zsl_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  zsl_pkg::cfg_idx_t  cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import zsl_pkg::*;

  logic job_push, q_full, job_pop, head_valid;
  job_t job_in, head_data;

  zsl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .job_push  (job_push),
    .job_data  (job_in),
    .q_full    (q_full)
  );

  zsl_job_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job_in),
    .full       (q_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  zsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job_data  (head_data),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* hdl/zsl_front.sv */
// front end: crc pipeline over the received body, then classification,
// link/learning state and request numbering; depends on zsl_pkg
module zsl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  zsl_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  zsl_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]        cfg_wdata,
  output logic              job_push,
  output zsl_pkg::job_t     job_data,
  input  logic              q_full
);
  import zsl_pkg::*;

  localparam int unsigned LAST_STG = CRC_STAGES - 1;

  function automatic logic [7:0] body_byte(input in_item_t it, input int unsigned k);
    logic [7:0] b;
    case (k)
      0:       b = it.frame_node;
      1:       b = it.frame_source;
      2:       b = it.frame_sequence;
      3:       b = it.frame_command;
      4:       b = it.frame_variant;
      5:       b = it.frame_zones;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // crc pipeline, one body byte per stage
  in_item_t               stg_item_r [CRC_STAGES];
  logic [7:0]             stg_crc_r  [CRC_STAGES];
  logic [CRC_STAGES-1:0]  stg_vld_r;
  logic                   advance;

  assign advance  = !(stg_vld_r[LAST_STG] && q_full);
  assign in_full  = !advance;
  assign job_push = stg_vld_r[LAST_STG] && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else if (advance) begin
      stg_vld_r <= {stg_vld_r[CRC_STAGES-2:0], in_push};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg_item_r[0] <= in_data;
      stg_crc_r[0]  <= crc_step(8'h00, in_data.frame_node);
      for (int k = 1; k < CRC_STAGES; k++) begin
        stg_item_r[k] <= stg_item_r[k-1];
        stg_crc_r[k]  <= crc_step(stg_crc_r[k-1], body_byte(stg_item_r[k-1], k));
      end
    end
  end

  // configuration
  logic [7:0] fallback_r, confirm_r, miss_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r   <= 8'd0;
      confirm_r    <= 8'd3;
      miss_limit_r <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FALLBACK:   fallback_r   <= cfg_wdata;
        REG_CONFIRM:    confirm_r    <= cfg_wdata;
        REG_MISS_LIMIT: miss_limit_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // link state
  logic [7:0] node_addr_r, learned_var_r, cand_node_r, cand_var_r;
  logic [7:0] cand_count_r, miss_count_r, next_seq_r, sent_seq_r;
  logic [5:0] known_mask_r;
  logic       locked_r, sent_seq_valid_r, wait_reply_r, wait_write_r;
  logic       mask_valid_r, link_online_r;

  logic [7:0] node_addr_nxt, learned_var_nxt, cand_node_nxt, cand_var_nxt;
  logic [7:0] cand_count_nxt, miss_count_nxt, next_seq_nxt, sent_seq_nxt;
  logic [5:0] known_mask_nxt;
  logic       locked_nxt, sent_seq_valid_nxt, wait_reply_nxt, wait_write_nxt;
  logic       mask_valid_nxt, link_online_nxt;

  in_item_t   it;
  logic [7:0] node_sel, miss_inc;
  logic       go_on, seq_ok, changed, online, is_tx;
  status_t    status;

  assign it = stg_item_r[LAST_STG];

  always_comb begin
    node_addr_nxt      = node_addr_r;
    learned_var_nxt    = learned_var_r;
    cand_node_nxt      = cand_node_r;
    cand_var_nxt       = cand_var_r;
    cand_count_nxt     = cand_count_r;
    miss_count_nxt     = miss_count_r;
    next_seq_nxt       = next_seq_r;
    sent_seq_nxt       = sent_seq_r;
    known_mask_nxt     = known_mask_r;
    locked_nxt         = locked_r;
    sent_seq_valid_nxt = sent_seq_valid_r;
    wait_reply_nxt     = wait_reply_r;
    wait_write_nxt     = wait_write_r;
    mask_valid_nxt     = mask_valid_r;
    link_online_nxt    = link_online_r;
    node_sel = (locked_r && node_addr_r != 8'd0) ? node_addr_r : fallback_r;
    miss_inc = sat_inc(miss_count_r);
    go_on    = 1'b0;
    seq_ok   = sent_seq_valid_r && (it.frame_sequence == sent_seq_r);
    changed  = 1'b0;
    online   = 1'b0;
    is_tx    = 1'b0;
    status   = ST_SKIP;

    if (it.mode == MODE_SEND) begin
      if (node_sel != 8'd0 && !it.bus_blocked) begin
        is_tx              = 1'b1;
        status             = ST_TX;
        next_seq_nxt       = (next_seq_r == 8'hFF) ? 8'd1 : next_seq_r + 8'd1;
        sent_seq_nxt       = next_seq_r;
        sent_seq_valid_nxt = 1'b1;
        wait_reply_nxt     = 1'b1;
        wait_write_nxt     = (it.request_arg != 8'd0);
      end
    end else if (it.frame_start != FRAME_SOF || it.frame_stop != FRAME_EOF) begin
      status = ST_FRAMING;
    end else if (stg_crc_r[LAST_STG] != it.frame_check) begin
      status = ST_CHECK;
    end else if (it.frame_source != SRC_STATUS || it.frame_command != CMD_STATUS) begin
      status = ST_OTHER;
    end else if ((it.frame_zones & ZONE_RSVD_MASK) != 8'd0) begin
      status = ST_MASK;
    end else begin
      go_on = 1'b1;
      // learning while unlocked
      if (!locked_r) begin
        if (it.frame_node == cand_node_r && it.frame_variant == cand_var_r) begin
          cand_count_nxt = sat_inc(cand_count_r);
        end else begin
          cand_node_nxt  = it.frame_node;
          cand_var_nxt   = it.frame_variant;
          cand_count_nxt = 8'd1;
        end
        node_addr_nxt = cand_node_nxt;
        if (cand_count_nxt < confirm_r) begin
          status = ST_PENDING;
          go_on  = 1'b0;
        end else begin
          learned_var_nxt = cand_var_nxt;
          locked_nxt      = 1'b1;
        end
      end
      if (go_on) begin
        if (it.frame_node != node_addr_nxt || it.frame_variant != learned_var_nxt) begin
          if (miss_inc >= miss_limit_r) begin
            status          = ST_UNLOCK;
            locked_nxt      = 1'b0;
            learned_var_nxt = 8'd0;
            cand_node_nxt   = it.frame_node;
            cand_var_nxt    = it.frame_variant;
            cand_count_nxt  = 8'd1;
            node_addr_nxt   = it.frame_node;
            miss_count_nxt  = 8'd0;
            mask_valid_nxt  = 1'b0;
            link_online_nxt = 1'b0;
            wait_reply_nxt  = 1'b0;
            wait_write_nxt  = 1'b0;
          end else begin
            status         = ST_MISMATCH;
            miss_count_nxt = miss_inc;
          end
        end else begin
          status          = ST_ACCEPT;
          miss_count_nxt  = 8'd0;
          changed         = !mask_valid_r || (it.frame_zones[5:0] != known_mask_r);
          online          = !link_online_r;
          node_addr_nxt   = it.frame_node;
          known_mask_nxt  = it.frame_zones[5:0];
          mask_valid_nxt  = 1'b1;
          link_online_nxt = 1'b1;
          // a write waits for its own sequence, a read for any status
          if (!wait_write_r || seq_ok) begin
            wait_reply_nxt = 1'b0;
            wait_write_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    job_data.is_tx          = is_tx;
    job_data.status         = status;
    job_data.node           = node_sel;
    job_data.seq            = next_seq_r;
    job_data.arg            = it.request_arg;
    job_data.zone_mask      = known_mask_nxt;
    job_data.mask_changed   = changed;
    job_data.link_came_up   = online;
    job_data.node_locked    = locked_nxt;
    job_data.node_address   = node_addr_nxt;
    job_data.awaiting_reply = wait_reply_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r      <= 8'd0;
      learned_var_r    <= 8'd0;
      cand_node_r      <= 8'd0;
      cand_var_r       <= 8'd0;
      cand_count_r     <= 8'd0;
      miss_count_r     <= 8'd0;
      next_seq_r       <= 8'd1;
      sent_seq_r       <= 8'd0;
      known_mask_r     <= 6'd0;
      locked_r         <= 1'b0;
      sent_seq_valid_r <= 1'b0;
      wait_reply_r     <= 1'b0;
      wait_write_r     <= 1'b0;
      mask_valid_r     <= 1'b0;
      link_online_r    <= 1'b0;
    end else if (job_push) begin
      node_addr_r      <= node_addr_nxt;
      learned_var_r    <= learned_var_nxt;
      cand_node_r      <= cand_node_nxt;
      cand_var_r       <= cand_var_nxt;
      cand_count_r     <= cand_count_nxt;
      miss_count_r     <= miss_count_nxt;
      next_seq_r       <= next_seq_nxt;
      sent_seq_r       <= sent_seq_nxt;
      known_mask_r     <= known_mask_nxt;
      locked_r         <= locked_nxt;
      sent_seq_valid_r <= sent_seq_valid_nxt;
      wait_reply_r     <= wait_reply_nxt;
      wait_write_r     <= wait_write_nxt;
      mask_valid_r     <= mask_valid_nxt;
      link_online_r    <= link_online_nxt;
    end
  end

endmodule

/* hdl/zsl_job_fifo.sv */
// short queue of classified items between front and back
// depends on zsl_pkg
module zsl_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  zsl_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output zsl_pkg::job_t head_data
);
  import zsl_pkg::*;

  job_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_push, do_pop;

  assign full       = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hdl/zsl_back.sv */
// back end: expands queued items into result beats, builds request frames
// byte by byte with a running crc; depends on zsl_pkg
module zsl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  zsl_pkg::job_t      job_data,
  output logic               job_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output zsl_pkg::out_item_t out_data
);
  import zsl_pkg::*;

  byte_idx_t  idx_r;
  logic [7:0] crc_r;
  out_item_t  out_r;
  logic       out_vld_r;
  logic       load, is_last;
  logic [7:0] tx_byte;
  out_item_t  res;

  assign load      = job_valid && (!out_vld_r || out_pop);
  assign is_last   = !job_data.is_tx || (idx_r == IDX_EOF);
  assign job_pop   = load && is_last;
  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    case (idx_r)
      IDX_SOF:  tx_byte = FRAME_SOF;
      IDX_SRC:  tx_byte = 8'h00;
      IDX_NODE: tx_byte = job_data.node;
      IDX_SEQ:  tx_byte = job_data.seq;
      IDX_CMD:  tx_byte = CMD_REQUEST;
      IDX_VAR:  tx_byte = 8'h00;
      IDX_ARG:  tx_byte = job_data.arg;
      IDX_CRC:  tx_byte = crc_r;
      IDX_EOF:  tx_byte = FRAME_EOF;
      default:  tx_byte = 8'h00;
    endcase
  end

  always_comb begin
    res.status         = job_data.status;
    res.tx_byte        = job_data.is_tx ? tx_byte : 8'h00;
    res.last           = is_last;
    res.zone_mask      = job_data.zone_mask;
    res.mask_changed   = job_data.mask_changed;
    res.link_came_up   = job_data.link_came_up;
    res.node_locked    = job_data.node_locked;
    res.node_address   = job_data.node_address;
    res.awaiting_reply = job_data.awaiting_reply;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= IDX_SOF;
    end else if (load) begin
      out_vld_r <= 1'b1;
      idx_r     <= is_last ? IDX_SOF : idx_r + 4'd1;
    end else if (out_pop) begin
      out_vld_r <= 1'b0;
    end
  end

  // crc runs over body bytes as they go out, ready by the check byte
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
      if (idx_r == IDX_SOF) begin
        crc_r <= 8'h00;
      end else if (idx_r < IDX_CRC) begin
        crc_r <= crc_step(crc_r, tx_byte);
      end
    end
  end

endmodule

/* hdl/zsl_checker.sv */
// port-level checks for the zone status link endpoint, bound to the top level
// depends on zsl_pkg and zone_status_link_endpoint_unit_defines.svh
`include "zone_status_link_endpoint_unit_defines.svh"

module zsl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input zsl_pkg::out_item_t out_data
);
  import zsl_pkg::*;

  // nothing waits on the result side right after reset
  `ZSL_ASSERT_ALWAYS(a_reset_empty, !rst_n, out_empty)

  // a waiting beat holds until taken
  `ZSL_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_data))

  // every sent request byte leaves a reply outstanding
  `ZSL_ASSERT_SAME(a_tx_waits, !out_empty && out_data.status == ST_TX, out_data.awaiting_reply)

  // publish flags only come with an accepted status frame
  `ZSL_ASSERT_SAME(a_flags_on_accept,
    !out_empty && (out_data.mask_changed || out_data.link_came_up),
    out_data.status == ST_ACCEPT && out_data.last)

endmodule

bind zone_status_link_endpoint_unit zsl_checker u_zsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

/* tb/zone_status_link_endpoint_unit_tb.sv */
// self-checking bench for zone_status_link_endpoint_unit: directed and random frames,
// requests and register settings, every result beat compared with a built-in predictor
// depends on zsl_pkg and the endpoint rtl
module zone_status_link_endpoint_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import zsl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 300;
  localparam int IDLE_PCT    = 38;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  in_item_t   in_data = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  cfg_idx_t   cfg_index = REG_FALLBACK;
  logic [7:0] cfg_wdata = 8'h00;

  zone_status_link_endpoint_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  in_item_t  pending_frames[$];
  out_item_t expected_beats[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        steady_run = 1'b0;
  bit        hold_request = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_cycles = 0;

  // register copies
  logic [7:0] fallback_addr = 8'h00;
  logic [7:0] confirm_goal = 8'd3;
  logic [7:0] miss_goal = 8'd3;

  // endpoint state as predicted
  logic [7:0] link_node = 8'h00;
  logic       link_locked = 1'b0;
  logic [7:0] link_variant = 8'h00;
  logic [7:0] cand_node = 8'h00;
  logic [7:0] cand_vnt = 8'h00;
  logic [7:0] cand_hits = 8'h00;
  logic [7:0] miss_hits = 8'h00;
  logic [7:0] seq_next = 8'h01;
  logic [7:0] seq_sent = 8'h00;
  logic       seq_sent_valid = 1'b0;
  logic       reply_pending = 1'b0;
  logic       reply_is_write = 1'b0;
  logic [5:0] zones_known = 6'h00;
  logic       zones_valid = 1'b0;
  logic       online = 1'b0;

  // sequence numbers as the stimulus side guesses them, for building replies
  logic [7:0] gen_next = 8'h01;
  logic [7:0] gen_last = 8'h00;

  // crc-8 reflected over the six body bytes, first byte in the top bits
  function automatic logic [7:0] body_crc(input logic [47:0] body);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 6; i++) begin
      c = c ^ body[47 - 8*i -: 8];
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic out_item_t make_beat(input status_t st, input logic [7:0] byte_v,
                                          input logic is_last, input logic changed,
                                          input logic came_up);
    out_item_t b;
    b.status         = st;
    b.tx_byte        = byte_v;
    b.last           = is_last;
    b.zone_mask      = zones_known;
    b.mask_changed   = changed;
    b.link_came_up   = came_up;
    b.node_locked    = link_locked;
    b.node_address   = link_node;
    b.awaiting_reply = reply_pending;
    return b;
  endfunction

  // classify one received frame and advance the learning state
  function automatic status_t judge_frame(input in_item_t it, output logic changed,
                                          output logic came_up);
    logic [5:0] zones;
    logic       seq_hit;
    changed = 1'b0;
    came_up = 1'b0;
    if (it.frame_start != FRAME_SOF || it.frame_stop != FRAME_EOF) return ST_FRAMING;
    if (body_crc({it.frame_node, it.frame_source, it.frame_sequence, it.frame_command,
                  it.frame_variant, it.frame_zones}) != it.frame_check) return ST_CHECK;
    if (it.frame_source != SRC_STATUS || it.frame_command != CMD_STATUS) return ST_OTHER;
    if ((it.frame_zones & ZONE_RSVD_MASK) != 8'h00) return ST_MASK;
    zones = it.frame_zones[5:0];
    if (!link_locked) begin
      if (it.frame_node == cand_node && it.frame_variant == cand_vnt) begin
        if (cand_hits != 8'hFF) cand_hits++;
      end else begin
        cand_node = it.frame_node;
        cand_vnt  = it.frame_variant;
        cand_hits = 8'd1;
      end
      link_node = cand_node;
      if (cand_hits < confirm_goal) return ST_PENDING;
      link_variant = cand_vnt;
      link_locked  = 1'b1;
    end
    if (it.frame_node != link_node || it.frame_variant != link_variant) begin
      if (miss_hits != 8'hFF) miss_hits++;
      if (miss_hits >= miss_goal) begin
        // mismatching frame restarts learning as the new candidate
        link_locked    = 1'b0;
        link_variant   = 8'h00;
        cand_node      = it.frame_node;
        cand_vnt       = it.frame_variant;
        cand_hits      = 8'd1;
        link_node      = it.frame_node;
        miss_hits      = 8'h00;
        zones_valid    = 1'b0;
        online         = 1'b0;
        reply_pending  = 1'b0;
        reply_is_write = 1'b0;
        return ST_UNLOCK;
      end
      return ST_MISMATCH;
    end
    miss_hits = 8'h00;
    seq_hit = seq_sent_valid && it.frame_sequence == seq_sent;
    changed = !zones_valid || zones != zones_known;
    link_node   = it.frame_node;
    zones_known = zones;
    zones_valid = 1'b1;
    // a write waits for its own sequence number, a read for any status
    if (!reply_is_write || seq_hit) begin
      reply_pending  = 1'b0;
      reply_is_write = 1'b0;
    end
    came_up = !online;
    online  = 1'b1;
    return ST_ACCEPT;
  endfunction

  task automatic predict_beats(input in_item_t it);
    logic [7:0] dest;
    logic [7:0] fb [9];
    status_t    st;
    logic       changed;
    logic       came_up;
    if (it.mode == MODE_SEND) begin
      dest = (link_locked && link_node != 8'h00) ? link_node : fallback_addr;
      if (dest == 8'h00 || it.bus_blocked) begin
        expected_beats.push_back(make_beat(ST_SKIP, 8'h00, 1'b1, 1'b0, 1'b0));
      end else begin
        fb[0] = FRAME_SOF;
        fb[1] = 8'h00;
        fb[2] = dest;
        fb[3] = seq_next;
        fb[4] = CMD_REQUEST;
        fb[5] = 8'h00;
        fb[6] = it.request_arg;
        fb[7] = body_crc({fb[1], fb[2], fb[3], fb[4], fb[5], fb[6]});
        fb[8] = FRAME_EOF;
        seq_next = seq_next + 8'd1;
        if (seq_next == 8'h00) seq_next = 8'h01;
        seq_sent       = fb[3];
        seq_sent_valid = 1'b1;
        reply_pending  = 1'b1;
        reply_is_write = it.request_arg != 8'h00;
        for (int i = 0; i < 9; i++) begin
          expected_beats.push_back(make_beat(ST_TX, fb[i], i == 8, 1'b0, 1'b0));
        end
      end
    end else begin
      st = judge_frame(it, changed, came_up);
      expected_beats.push_back(make_beat(st, 8'h00, 1'b1, changed, came_up));
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_beat(input out_item_t got, input out_item_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.tx_byte !== want.tx_byte)
      report_mismatch($sformatf("tx_byte got %h want %h", got.tx_byte, want.tx_byte));
    if (got.last !== want.last)
      report_mismatch($sformatf("last got %b want %b", got.last, want.last));
    if (got.zone_mask !== want.zone_mask)
      report_mismatch($sformatf("zone_mask got %h want %h", got.zone_mask, want.zone_mask));
    if (got.mask_changed !== want.mask_changed)
      report_mismatch($sformatf("mask_changed got %b want %b",
                                got.mask_changed, want.mask_changed));
    if (got.link_came_up !== want.link_came_up)
      report_mismatch($sformatf("link_came_up got %b want %b",
                                got.link_came_up, want.link_came_up));
    if (got.node_locked !== want.node_locked)
      report_mismatch($sformatf("node_locked got %b want %b",
                                got.node_locked, want.node_locked));
    if (got.node_address !== want.node_address)
      report_mismatch($sformatf("node_address got %h want %h",
                                got.node_address, want.node_address));
    if (got.awaiting_reply !== want.awaiting_reply)
      report_mismatch($sformatf("awaiting_reply got %b want %b",
                                got.awaiting_reply, want.awaiting_reply));
  endtask

  // input side: offer the next queued item, hold it while the block is full
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) predict_beats(in_data);
      if (!in_push || !in_full) begin
        if (pending_frames.size() > 0 && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
          in_data <= pending_frames.pop_front();
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result side: check each popped beat, stall at random or for the long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_beats.size() == 0) report_mismatch("result beat with nothing expected");
        else check_beat(out_data, expected_beats.pop_front());
      end
      if (hold_request && !hold_done) begin
        out_pop <= 1'b0;
        hold_cycles++;
        if (hold_cycles >= HOLD_LEN) hold_done = 1'b1;
      end else begin
        out_pop <= steady_run || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("zone_status_link_endpoint_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic in_item_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t rx_frame(input logic [7:0] node, input logic [7:0] src,
                                        input logic [7:0] seq, input logic [7:0] cmd,
                                        input logic [7:0] vnt, input logic [7:0] zones);
    in_item_t it;
    it = noise_item();
    it.mode           = MODE_RECEIVE;
    it.frame_start    = FRAME_SOF;
    it.frame_node     = node;
    it.frame_source   = src;
    it.frame_sequence = seq;
    it.frame_command  = cmd;
    it.frame_variant  = vnt;
    it.frame_zones    = zones;
    it.frame_check    = body_crc({node, src, seq, cmd, vnt, zones});
    it.frame_stop     = FRAME_EOF;
    return it;
  endfunction

  function automatic in_item_t status_frame(input logic [7:0] node, input logic [7:0] vnt,
                                            input logic [7:0] seq, input logic [7:0] zones);
    return rx_frame(node, SRC_STATUS, seq, CMD_STATUS, vnt, zones);
  endfunction

  task automatic queue_request(input logic [7:0] arg, input logic blocked);
    in_item_t it;
    it = noise_item();
    it.mode        = MODE_SEND;
    it.request_arg = arg;
    it.bus_blocked = blocked;
    pending_frames.push_back(it);
    if (!blocked) begin
      gen_last = gen_next;
      gen_next = gen_next + 8'd1;
      if (gen_next == 8'h00) gen_next = 8'h01;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_frames.size() != 0 || in_push || expected_beats.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] fb, input logic [7:0] conf,
                          input logic [7:0] miss);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FALLBACK;
    cfg_wdata <= fb;
    @(posedge clk);
    cfg_index <= REG_CONFIRM;
    cfg_wdata <= conf;
    @(posedge clk);
    cfg_index <= REG_MISS_LIMIT;
    cfg_wdata <= miss;
    @(posedge clk);
    cfg_we <= 1'b0;
    fallback_addr = fb;
    confirm_goal  = conf;
    miss_goal     = miss;
    gen_next = seq_next;
    gen_last = seq_sent;
  endtask

  // mostly well-formed status traffic around one favored node, plus requests and junk
  task automatic run_random(input int count, input logic [7:0] fav_node,
                            input logic [7:0] fav_vnt);
    int         pick;
    logic [7:0] node_v;
    logic [7:0] vnt_v;
    logic [7:0] seq_v;
    logic [7:0] zones_v;
    logic [5:0] cur_mask;
    in_item_t   it;
    cur_mask = 6'($urandom);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        queue_request($urandom_range(1) ? 8'h00 : 8'($urandom), $urandom_range(99) < 15);
      end else if (pick < 90) begin
        if ($urandom_range(3) == 0) cur_mask = 6'($urandom);
        zones_v = ($urandom_range(9) == 0) ? 8'($urandom) : {2'b00, cur_mask};
        seq_v = ($urandom_range(9) < 7) ? gen_last : 8'($urandom);
        node_v = fav_node;
        vnt_v = fav_vnt;
        if ($urandom_range(4) == 0) begin
          case ($urandom_range(3))
            0: node_v = 8'h00;
            1: node_v = 8'hFF;
            2: node_v = 8'($urandom);
            default: vnt_v = 8'($urandom);
          endcase
        end
        it = status_frame(node_v, vnt_v, seq_v, zones_v);
        if (pick >= 78) begin
          // broken frame of one kind or another
          case ($urandom_range(4))
            0: it.frame_start = FRAME_SOF ^ 8'($urandom_range(1, 255));
            1: it.frame_stop = FRAME_EOF ^ 8'($urandom_range(1, 255));
            2: it.frame_check = it.frame_check ^ 8'($urandom_range(1, 255));
            3: it = rx_frame(node_v, 8'($urandom_range(1, 255)), seq_v, CMD_STATUS,
                             vnt_v, zones_v);
            default: it = rx_frame(node_v, SRC_STATUS, seq_v,
                                   CMD_STATUS ^ 8'($urandom_range(1, 255)), vnt_v, zones_v);
          endcase
        end
        pending_frames.push_back(it);
      end else begin
        it = noise_item();
        it.mode = MODE_RECEIVE;
        pending_frames.push_back(it);
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] fb, input logic [7:0] conf,
                           input logic [7:0] miss, input int count,
                           input logic [7:0] fav_node, input logic [7:0] fav_vnt,
                           input bit with_hold);
    wait_drained();
    steady_run = 1'b0;
    set_regs(fb, conf, miss);
    if (with_hold) begin
      // sender keeps offering while the result side is held off
      steady_run   = 1'b1;
      hold_request = 1'b1;
    end
    run_random(count, fav_node, fav_vnt);
  endtask

  initial begin
    in_item_t it;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // default registers: nothing to send to, learning, framing, check, source/command and zone mask failures
    queue_request(8'h10, 1'b0);
    pending_frames.push_back(status_frame(8'h21, 8'h07, 8'h00, 8'h3F));
    it = status_frame(8'h21, 8'h07, 8'h00, 8'h3F);
    it.frame_start = 8'h00;
    pending_frames.push_back(it);
    it = status_frame(8'h21, 8'h07, 8'h00, 8'h3F);
    it.frame_stop = 8'hFF;
    pending_frames.push_back(it);
    it = status_frame(8'h21, 8'h07, 8'h00, 8'h3F);
    it.frame_check = ~it.frame_check;
    pending_frames.push_back(it);
    pending_frames.push_back(rx_frame(8'h21, 8'hFF, 8'h00, CMD_STATUS, 8'h07, 8'h3F));
    pending_frames.push_back(rx_frame(8'h21, SRC_STATUS, 8'h00, CMD_REQUEST, 8'h07, 8'h3F));
    pending_frames.push_back(status_frame(8'h21, 8'h07, 8'h00, 8'hC0));
    pending_frames.push_back(status_frame(8'h21, 8'h07, 8'h00, 8'h40));
    wait_drained();

    // learn, lock, write reply matching, mismatches up to the unlock
    set_regs(8'hA5, 8'd3, 8'd3);
    queue_request(8'h00, 1'b1);
    queue_request(8'h00, 1'b0);
    pending_frames.push_back(status_frame(8'h21, 8'h07, gen_last, 8'h3F));
    pending_frames.push_back(status_frame(8'h21, 8'h07, 8'h77, 8'h3F));
    queue_request(8'hFF, 1'b0);
    pending_frames.push_back(status_frame(8'h21, 8'h07, gen_last ^ 8'h01, 8'h3F));
    pending_frames.push_back(status_frame(8'h21, 8'h07, gen_last, 8'h00));
    pending_frames.push_back(status_frame(8'h22, 8'h07, 8'h00, 8'h00));
    pending_frames.push_back(status_frame(8'h21, 8'h08, 8'h00, 8'h00));
    pending_frames.push_back(status_frame(8'hFF, 8'hFF, 8'hFF, 8'h3F));
    queue_request(8'h01, 1'b0);
    pending_frames.push_back(in_item_t'('0));
    it = in_item_t'('1);
    it.mode = MODE_RECEIVE;
    pending_frames.push_back(it);
    pending_frames.push_back(in_item_t'('1));
    pending_frames.push_back(status_frame(8'h00, 8'h00, 8'h00, 8'h00));

    run_phase(8'hA5, 8'd3,   8'd3,   40, 8'h21, 8'h07, 1'b0);
    run_phase(8'hFF, 8'd1,   8'd1,   30, 8'hFF, 8'hFF, 1'b1);
    run_phase(8'h00, 8'd0,   8'd0,   20, 8'h00, 8'h00, 1'b0);
    run_phase(8'h01, 8'd255, 8'd255, 20, 8'h5C, 8'h3A, 1'b0);
    run_phase(8'h3C, 8'd2,   8'd4,   30, 8'h01, 8'h80, 1'b0);

    // a burst of sent requests back to back
    wait_drained();
    set_regs(8'h80, 8'd3, 8'd3);
    steady_run = 1'b1;
    for (int n = 0; n < 40; n++) queue_request(8'($urandom), 1'b0);
    run_phase(8'h80, 8'd3, 8'd3, 25, 8'h21, 8'h07, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("zone_status_link_endpoint_unit_tb: PASS");
    end else begin
      $display("zone_status_link_endpoint_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
